// ----- sv/iir2bq_pkg.sv -----
// ============================================================================
// iir2bq_pkg
// Shared types and constants of the two-section biquad cascade: register
// indexes, coefficient bundle and the controller-to-datapath command word.
// ============================================================================
package iir2bq_pkg;

    // coefficient fields are always 16 bits, whatever their fraction count
    localparam int COEF_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [COEF_W-1:0] GAIN_RESET = 16'h2000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_GAIN         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FEEDBACK     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FEEDFORWARD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_GAIN        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_FEEDBACK    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_FEEDFORWARD = 3'd5;

    typedef struct packed {
        logic signed [COEF_W-1:0] g;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
    } t_sec_coef;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // one step per cycle in a section; section two's last step may stall
    typedef enum logic [2:0] {
        STEP_G,
        STEP_A1,
        STEP_A2,
        STEP_B1,
        STEP_B2,
        STEP_ACC,
        STEP_END
    } t_step;

    // product term selected for the shared multiplier
    typedef enum logic [2:0] {
        TERM_G,
        TERM_A1,
        TERM_A2,
        TERM_B1,
        TERM_B2
    } t_term;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_SUB,
        ACC_VADD,
        ACC_ADD
    } t_acc_op;

    typedef struct packed {
        logic    load_x;
        logic    mul_en;
        t_term   term;
        t_acc_op acc_op;
        logic    finish;
        logic    out_load;
        logic    sec;
    } t_dp_cmd;

endpackage

// ----- sv/iir_two_biquad_cascade.sv -----
// ============================================================================
// iir_two_biquad_cascade
// Fourth-order fixed-point IIR filter of two cascaded direct form II biquads.
// ============================================================================
// One sample in, one sample out. A new sample is taken only while the filter
// is idle; it then steps through both sections in turn on a single shared
// multiplier, which does the five coefficient products of a section one per
// cycle with a registered product and a saturating accumulator behind it.
// The result lands in an output register and the filter is ready again in
// the same cycle, so a new sample can follow at once as long as the result of
// the previous sample has been taken; if it has not, the filter holds its
// final step until the output register frees up. Samples are Q1.15,
// coefficients Q3.13 in 16-bit fields, delay state Q5.27 (for the default
// widths); products floor to state format, both sums of a section saturate
// to state width, and the output floors and saturates to sample width.
// Coefficient registers take effect on the next sample and should only be
// written while the filter is idle. Delay state is cleared by reset.
// ============================================================================
module iir_two_biquad_cascade #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEFF_WIDTH  = 16,
    parameter int STATE_WIDTH  = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [iir2bq_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [iir2bq_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // sample input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [SAMPLE_WIDTH-1:0]             i_sample_in,
    // sample output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [SAMPLE_WIDTH-1:0]             o_sample_out
);
    import iir2bq_pkg::*;

    // coefficient registers, index 0 is section one
    logic [COEF_W-1:0]     r_gain [2];
    logic [CFG_DATA_W-1:0] r_fb   [2];
    logic [CFG_DATA_W-1:0] r_ff   [2];

    t_sec_coef [1:0] coef;
    t_dp_cmd         cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain[0] <= GAIN_RESET;
            r_gain[1] <= GAIN_RESET;
            r_fb[0]   <= '0;
            r_fb[1]   <= '0;
            r_ff[0]   <= '0;
            r_ff[1]   <= '0;
        end else if (i_cfg_we) begin
            // writes to unused indexes are dropped
            unique case (i_cfg_idx)
                CFG_FIRST_GAIN:         r_gain[0] <= i_cfg_data[COEF_W-1:0];
                CFG_FIRST_FEEDBACK:     r_fb[0]   <= i_cfg_data;
                CFG_FIRST_FEEDFORWARD:  r_ff[0]   <= i_cfg_data;
                CFG_SECOND_GAIN:        r_gain[1] <= i_cfg_data[COEF_W-1:0];
                CFG_SECOND_FEEDBACK:    r_fb[1]   <= i_cfg_data;
                CFG_SECOND_FEEDFORWARD: r_ff[1]   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // unpack a1/a2 and b1/b2 from their packed words
    always_comb begin
        for (int s = 0; s < 2; s++) begin
            coef[s].g  = r_gain[s];
            coef[s].a1 = r_fb[s][CFG_DATA_W-1:COEF_W];
            coef[s].a2 = r_fb[s][COEF_W-1:0];
            coef[s].b1 = r_ff[s][CFG_DATA_W-1:COEF_W];
            coef[s].b2 = r_ff[s][COEF_W-1:0];
        end
    end

    iir2bq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    iir2bq_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEFF_WIDTH  (COEFF_WIDTH),
        .STATE_WIDTH  (STATE_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_coef       (coef),
        .i_sample_in  (i_sample_in),
        .o_sample_out (o_sample_out)
    );

endmodule

// ----- sv/iir2bq_ctrl.sv -----
// ============================================================================
// iir2bq_ctrl
// Sequencer for the cascade: steps both sections through the shared
// multiplier and accumulator and owns the handshake of both channels.
// ============================================================================
module iir2bq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output iir2bq_pkg::t_dp_cmd o_cmd
);
    import iir2bq_pkg::*;

    t_state  r_state, n_state;
    t_step   r_step, n_step;
    logic    r_sec, n_sec;
    logic    r_out_valid, n_out_valid;
    t_dp_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= STEP_G;
            r_sec       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_sec       <= n_sec;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_step          = r_step;
        n_sec           = r_sec;
        o_in_ready      = 1'b0;
        cmd.load_x      = 1'b0;
        cmd.mul_en      = 1'b0;
        cmd.term        = TERM_G;
        cmd.acc_op      = ACC_NONE;
        cmd.finish      = 1'b0;
        cmd.out_load    = 1'b0;
        cmd.sec         = r_sec;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.load_x = 1'b1;
                    n_state    = ST_RUN;
                    n_step     = STEP_G;
                    n_sec      = 1'b0;
                end
            end
            ST_RUN: begin
                unique case (r_step)
                    STEP_G: begin
                        cmd.mul_en = 1'b1;
                        cmd.term   = TERM_G;
                        n_step     = STEP_A1;
                    end
                    STEP_A1: begin
                        cmd.mul_en = 1'b1;
                        cmd.term   = TERM_A1;
                        cmd.acc_op = ACC_LOAD;
                        n_step     = STEP_A2;
                    end
                    STEP_A2: begin
                        cmd.mul_en = 1'b1;
                        cmd.term   = TERM_A2;
                        cmd.acc_op = ACC_SUB;
                        n_step     = STEP_B1;
                    end
                    STEP_B1: begin
                        cmd.mul_en = 1'b1;
                        cmd.term   = TERM_B1;
                        cmd.acc_op = ACC_SUB;
                        n_step     = STEP_B2;
                    end
                    STEP_B2: begin
                        cmd.mul_en = 1'b1;
                        cmd.term   = TERM_B2;
                        cmd.acc_op = ACC_VADD;
                        n_step     = STEP_ACC;
                    end
                    STEP_ACC: begin
                        cmd.acc_op = ACC_ADD;
                        n_step     = STEP_END;
                    end
                    STEP_END: begin
                        if (!r_sec) begin
                            cmd.finish = 1'b1;
                            n_sec      = 1'b1;
                            n_step     = STEP_G;
                        end else if (!r_out_valid || i_out_ready) begin
                            // wait here while the previous result is still held
                            cmd.finish   = 1'b1;
                            cmd.out_load = 1'b1;
                            n_state      = ST_IDLE;
                            n_step       = STEP_G;
                        end
                    end
                    default: begin
                        n_step = STEP_G;
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ----- sv/iir2bq_dp.sv -----
// ============================================================================
// iir2bq_dp
// Datapath: format conversion, one shared multiplier, saturating
// accumulator, delay state of both sections and the output register.
// ============================================================================
module iir2bq_dp #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEFF_WIDTH  = 16,
    parameter int STATE_WIDTH  = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  iir2bq_pkg::t_dp_cmd              i_cmd,
    input  iir2bq_pkg::t_sec_coef [1:0]      i_coef,
    input  logic [SAMPLE_WIDTH-1:0]          i_sample_in,
    output logic [SAMPLE_WIDTH-1:0]          o_sample_out
);
    import iir2bq_pkg::*;

    localparam int CFRAC       = COEFF_WIDTH - 3;
    localparam int SFRAC       = STATE_WIDTH - 5;
    localparam int IN_TO_STATE = SFRAC - (SAMPLE_WIDTH - 1);
    localparam int SH_UP       = (IN_TO_STATE > 0) ? IN_TO_STATE : 0;
    localparam int SH_DN       = (IN_TO_STATE < 0) ? -IN_TO_STATE : 0;
    localparam int PROD_W      = STATE_WIDTH + COEF_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int CONV_W      = STATE_WIDTH + SAMPLE_WIDTH;

    localparam logic signed [ACC_W-1:0] ST_MAX =
        {{(ACC_W-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ST_MIN =
        {{(ACC_W-STATE_WIDTH+1){1'b1}}, {(STATE_WIDTH-1){1'b0}}};
    localparam logic signed [CONV_W-1:0] SM_MAX =
        {{(CONV_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [CONV_W-1:0] SM_MIN =
        {{(CONV_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [STATE_WIDTH-1:0] r_d1 [2];
    logic signed [STATE_WIDTH-1:0] r_d2 [2];
    logic signed [STATE_WIDTH-1:0] r_x;
    logic signed [STATE_WIDTH-1:0] r_v;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [ACC_W-1:0]       r_acc;
    logic        [SAMPLE_WIDTH-1:0] r_out;

    logic signed [CONV_W-1:0]      x_ext, x_scl, y_ext, y_scl;
    logic signed [STATE_WIDTH-1:0] mul_val, acc_sat;
    logic signed [COEF_W-1:0]      mul_coef;
    logic signed [PROD_W-1:0]      prod_full;
    logic signed [ACC_W-1:0]       p_ext, acc_sat_ext;
    logic        [SAMPLE_WIDTH-1:0] out_sat;
    t_sec_coef                     coef;

    // input sample to state format, always in range
    assign x_ext = {{(CONV_W-SAMPLE_WIDTH){i_sample_in[SAMPLE_WIDTH-1]}}, i_sample_in};
    assign x_scl = (x_ext <<< SH_UP) >>> SH_DN;

    assign coef = i_coef[i_cmd.sec];

    always_comb begin
        unique case (i_cmd.term)
            TERM_G: begin
                mul_val  = r_x;
                mul_coef = coef.g;
            end
            TERM_A1: begin
                mul_val  = r_d1[i_cmd.sec];
                mul_coef = coef.a1;
            end
            TERM_A2: begin
                mul_val  = r_d2[i_cmd.sec];
                mul_coef = coef.a2;
            end
            TERM_B1: begin
                mul_val  = r_d1[i_cmd.sec];
                mul_coef = coef.b1;
            end
            TERM_B2: begin
                mul_val  = r_d2[i_cmd.sec];
                mul_coef = coef.b2;
            end
            default: begin
                mul_val  = r_x;
                mul_coef = coef.g;
            end
        endcase
    end

    assign prod_full = mul_val * mul_coef;

    assign p_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    // saturate accumulator to state width
    always_comb begin
        if (r_acc > ST_MAX) begin
            acc_sat = ST_MAX[STATE_WIDTH-1:0];
        end else if (r_acc < ST_MIN) begin
            acc_sat = ST_MIN[STATE_WIDTH-1:0];
        end else begin
            acc_sat = r_acc[STATE_WIDTH-1:0];
        end
    end

    assign acc_sat_ext = {{(ACC_W-STATE_WIDTH){acc_sat[STATE_WIDTH-1]}}, acc_sat};

    // state format back to sample format, floor then saturate
    assign y_ext = {{(CONV_W-STATE_WIDTH){acc_sat[STATE_WIDTH-1]}}, acc_sat};
    assign y_scl = (y_ext <<< SH_DN) >>> SH_UP;

    always_comb begin
        if (y_scl > SM_MAX) begin
            out_sat = SM_MAX[SAMPLE_WIDTH-1:0];
        end else if (y_scl < SM_MIN) begin
            out_sat = SM_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            out_sat = y_scl[SAMPLE_WIDTH-1:0];
        end
    end

    // delay state, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1[0] <= '0;
            r_d1[1] <= '0;
            r_d2[0] <= '0;
            r_d2[1] <= '0;
        end else if (i_cmd.finish) begin
            r_d2[i_cmd.sec] <= r_d1[i_cmd.sec];
            r_d1[i_cmd.sec] <= r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_x <= x_scl[STATE_WIDTH-1:0];
        end else if (i_cmd.finish) begin
            // section one output feeds section two at full precision
            r_x <= acc_sat;
        end

        if (i_cmd.mul_en) begin
            r_prod <= prod_full >>> CFRAC;
        end

        unique case (i_cmd.acc_op)
            ACC_NONE: begin
                r_acc <= r_acc;
            end
            ACC_LOAD: begin
                r_acc <= p_ext;
            end
            ACC_SUB: begin
                r_acc <= r_acc - p_ext;
            end
            ACC_VADD: begin
                r_v   <= acc_sat;
                r_acc <= acc_sat_ext + p_ext;
            end
            ACC_ADD: begin
                r_acc <= r_acc + p_ext;
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase

        if (i_cmd.out_load) begin
            r_out <= out_sat;
        end
    end

    assign o_sample_out = r_out;

endmodule

// ----- sv/iir2bq_checker.sv -----
// ============================================================================
// iir2bq_checker
// Port-level checks of the cascade's sample channels, bound to the top level.
// ============================================================================
module iir2bq_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic [SAMPLE_WIDTH-1:0] o_sample_out
);

    // nothing is pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // one sample at a time: the input is not taken again straight after a transfer
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready ##1 !o_in_ready)
        else $error("input taken again too soon");

    // a new result coincides with the filter going idle
    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result shown while still busy");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_sample_out)))
        else $error("stalled result dropped or changed");

endmodule

bind iir_two_biquad_cascade iir2bq_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_iir2bq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_sample_out (o_sample_out)
);

// ----- tb/tb.sv -----
// ============================================================================
// tb
// Self-checking bench for the two-section biquad cascade filter.
// ============================================================================
// A short table of directed rows (reset coefficients, saturating gains,
// extreme feedback and feedforward fields, writes to unused register indexes)
// is followed by random phases. Each phase writes all six coefficient
// registers while the filter is idle and then streams samples.
// A fixed-point predictor of the cascade runs in step with every accepted
// sample. Both handshake sides idle in short random bursts in most phases.
// The receiver also holds off once for a long stretch so the filter backs up.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import iir2bq_pkg::*;

    localparam int SMP_W      = 16;
    localparam int ST_W       = 32;
    localparam int CFRAC      = 13;
    localparam int IN_SHIFT   = 12;   // sample fraction bits up to state fraction bits
    localparam int SETTLE_CYC = 20;   // well above the run of one sample
    localparam int HOLD_CYC   = 400;
    localparam int HOLD_AFTER = 450;
    localparam int PHASE_LEN  = 305;
    localparam int NUM_PHASES = 6;

    // register indexes past the last coefficient register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // a well-behaved section: double pole at 0.8, zeros at -1
    localparam logic [31:0] CALM_FEEDBACK    = {16'hCCCD, 16'h147B};
    localparam logic [31:0] CALM_FEEDFORWARD = {16'h4000, 16'h2000};

    typedef enum logic {
        ROW_CFG,
        ROW_SAMPLE
    } t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [SMP_W-1:0]       sample;
        bit                     known;
        logic [SMP_W-1:0]       result;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [SMP_W-1:0]       i_sample_in;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [SMP_W-1:0]       o_sample_out;

    // predictor copy of the coefficient registers and delay lines
    logic [CFG_DATA_W-1:0]  coef_reg [6];
    longint                 delay_line [4];   // d1, d2 of section one, then section two

    logic [SMP_W-1:0]       filtered_due [$];
    t_row                   directed_rows [$];
    int                     errors       = 0;
    int                     results_seen = 0;
    int                     in_idle_pct  = 0;
    int                     out_idle_pct = 0;
    bit                     quiet_tail   = 1'b0;

    iir_two_biquad_cascade u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // fixed-point predictor
    // ------------------------------------------------------------------------

    function automatic longint clamp(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // exact product, floored back to state format
    function automatic longint coef_mul(longint v, logic signed [COEF_W-1:0] c);
        longint cc;
        cc = c;
        return (v * cc) >>> CFRAC;
    endfunction

    function automatic longint biquad(longint x, int sec);
        logic signed [COEF_W-1:0] g, a1, a2, b1, b2;
        longint d1, d2, v, y;
        g  = coef_reg[3*sec][15:0];
        a1 = coef_reg[3*sec+1][31:16];
        a2 = coef_reg[3*sec+1][15:0];
        b1 = coef_reg[3*sec+2][31:16];
        b2 = coef_reg[3*sec+2][15:0];
        d1 = delay_line[2*sec];
        d2 = delay_line[2*sec+1];
        v  = clamp(coef_mul(x, g) - coef_mul(d1, a1) - coef_mul(d2, a2), ST_W);
        y  = clamp(v + coef_mul(d1, b1) + coef_mul(d2, b2), ST_W);
        delay_line[2*sec+1] = d1;
        delay_line[2*sec]   = v;
        return y;
    endfunction

    function automatic logic [SMP_W-1:0] filter_sample(logic [SMP_W-1:0] s);
        longint x;
        longint y;
        x = longint'($signed(s)) <<< IN_SHIFT;
        y = biquad(biquad(x, 0), 1);
        return SMP_W'(clamp(y >>> IN_SHIFT, SMP_W));
    endfunction

    function automatic void store_coef(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        if (idx == CFG_FIRST_GAIN || idx == CFG_SECOND_GAIN)
            coef_reg[idx] = {16'h0000, d[15:0]};
        else if (idx <= CFG_SECOND_FEEDFORWARD)
            coef_reg[idx] = d;
        // spare indexes fall through untouched
    endfunction

    // one of the four corner codes of a 16-bit field
    function automatic logic [15:0] corner16();
        case ($urandom_range(0, 3))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'hFFFF;
            default: return 16'h0000;
        endcase
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        t_row r;
        r = '{ROW_CFG, idx, d, '0, 1'b0, '0};
        directed_rows.push_back(r);
    endfunction

    function automatic void add_sample(logic [SMP_W-1:0] s, bit known, logic [SMP_W-1:0] res);
        t_row r;
        r = '{ROW_SAMPLE, '0, '0, s, known, res};
        directed_rows.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // driving tasks
    // ------------------------------------------------------------------------

    // valid goes up and stays up until the transfer happens
    task automatic send_sample(input logic [SMP_W-1:0] s, input bit known,
                               input logic [SMP_W-1:0] res);
        logic [SMP_W-1:0] predicted;
        i_in_valid  <= 1'b1;
        i_sample_in <= s;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = filter_sample(s);
        filtered_due.push_back(known ? res : predicted);
        if (!quiet_tail && $urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // drain everything in flight, then give the datapath time to go idle
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (filtered_due.size() != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        store_coef(idx, d);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // result side: random ready bursts plus one long hold-off
    // ------------------------------------------------------------------------

    initial begin : out_side
        bit hold_done;
        hold_done = 1'b0;
        i_out_ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                // long stall while the sender keeps pushing: input must back up
                hold_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYC) @(posedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 99) < out_idle_pct) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // compare every output transfer with the oldest prediction
    always @(posedge i_clk) begin
        logic [SMP_W-1:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (filtered_due.size() == 0) begin
                $display("%0t: unexpected sample_out %0d", $time, $signed(o_sample_out));
                errors++;
            end else begin
                want = filtered_due.pop_front();
                if (o_sample_out !== want) begin
                    $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                             $time, $signed(want), $signed(o_sample_out));
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial begin : stimulus
        logic [SMP_W-1:0] s;
        logic [15:0]      g1, g2;
        coef_reg[CFG_FIRST_GAIN]         = {16'h0000, GAIN_RESET};
        coef_reg[CFG_FIRST_FEEDBACK]     = '0;
        coef_reg[CFG_FIRST_FEEDFORWARD]  = '0;
        coef_reg[CFG_SECOND_GAIN]        = {16'h0000, GAIN_RESET};
        coef_reg[CFG_SECOND_FEEDBACK]    = '0;
        coef_reg[CFG_SECOND_FEEDFORWARD] = '0;
        foreach (delay_line[k]) delay_line[k] = 0;

        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_FIRST_GAIN;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_sample_in <= '0;

        // reset coefficients make each section a pass-through
        add_sample(16'h8000, 1'b1, 16'h8000);
        add_sample(16'h7FFF, 1'b1, 16'h7FFF);
        add_sample(16'h0000, 1'b1, 16'h0000);
        add_sample(16'hFFFF, 1'b1, 16'hFFFF);
        add_sample(16'h0001, 1'b1, 16'h0001);
        add_sample(16'h5555, 1'b1, 16'h5555);
        add_sample(16'hAAAA, 1'b1, 16'hAAAA);
        // writes to unused indexes change nothing
        add_cfg(CFG_SPARE_LO, 32'hFFFF_FFFF);
        add_cfg(CFG_SPARE_HI, 32'h1234_5678);
        add_sample(16'h1234, 1'b1, 16'h1234);
        // largest gains: output clips, upper gain bits are dropped
        add_cfg(CFG_FIRST_GAIN, 32'hABCD_7FFF);
        add_cfg(CFG_SECOND_GAIN, 32'h0000_7FFF);
        add_sample(16'h7FFF, 1'b1, 16'h7FFF);
        add_sample(16'h8000, 1'b1, 16'h8000);
        add_sample(16'h0000, 1'b1, 16'h0000);
        // most negative gains
        add_cfg(CFG_FIRST_GAIN, 32'h0000_8000);
        add_cfg(CFG_SECOND_GAIN, 32'hFFFF_8000);
        add_sample(16'h7FFF, 1'b0, '0);
        add_sample(16'h8000, 1'b0, '0);
        // corner feedback and feedforward fields drive the sums into saturation
        add_cfg(CFG_FIRST_GAIN, {16'h0000, GAIN_RESET});
        add_cfg(CFG_SECOND_GAIN, {16'h0000, GAIN_RESET});
        add_cfg(CFG_FIRST_FEEDBACK, 32'h7FFF_8000);
        add_cfg(CFG_FIRST_FEEDFORWARD, 32'h8000_7FFF);
        add_cfg(CFG_SECOND_FEEDBACK, 32'h8000_8000);
        add_cfg(CFG_SECOND_FEEDFORWARD, 32'h7FFF_7FFF);
        repeat (3) add_sample(16'h7FFF, 1'b0, '0);
        repeat (3) add_sample(16'h8000, 1'b0, '0);
        repeat (2) add_sample(16'h0000, 1'b0, '0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        in_idle_pct  = 25;
        out_idle_pct = 25;
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                settle();
                write_coef(directed_rows[r].idx, directed_rows[r].data);
            end else begin
                send_sample(directed_rows[r].sample, directed_rows[r].known,
                            directed_rows[r].result);
            end
        end

        // random phases, each with its own coefficient set
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            in_idle_pct  = (ph == 3) ? 0 : $urandom_range(5, 40);
            out_idle_pct = (ph == 3) ? 0 : $urandom_range(5, 40);
            g1 = 16'($urandom_range(40, 120));
            g2 = 16'($urandom_range(2000, 9000));
            case (ph)
                0, 5: begin
                    // calm low-pass in both sections
                    write_coef(CFG_FIRST_GAIN, {16'($urandom), g1});
                    write_coef(CFG_FIRST_FEEDBACK, CALM_FEEDBACK);
                    write_coef(CFG_FIRST_FEEDFORWARD, CALM_FEEDFORWARD);
                    write_coef(CFG_SECOND_GAIN, {16'h0000, g2});
                    write_coef(CFG_SECOND_FEEDBACK, CALM_FEEDBACK);
                    write_coef(CFG_SECOND_FEEDFORWARD, CALM_FEEDFORWARD);
                end
                1: begin
                    // anything goes, often unstable and saturating
                    write_coef(CFG_FIRST_GAIN, $urandom);
                    write_coef(CFG_FIRST_FEEDBACK, $urandom);
                    write_coef(CFG_FIRST_FEEDFORWARD, $urandom);
                    write_coef(CFG_SECOND_GAIN, $urandom);
                    write_coef(CFG_SECOND_FEEDBACK, $urandom);
                    write_coef(CFG_SECOND_FEEDFORWARD, $urandom);
                end
                2: begin
                    // corner codes in every field
                    write_coef(CFG_FIRST_GAIN, {16'h0000, corner16()});
                    write_coef(CFG_FIRST_FEEDBACK, {corner16(), corner16()});
                    write_coef(CFG_FIRST_FEEDFORWARD, {corner16(), corner16()});
                    write_coef(CFG_SECOND_GAIN, {16'h0000, corner16()});
                    write_coef(CFG_SECOND_FEEDBACK, {corner16(), corner16()});
                    write_coef(CFG_SECOND_FEEDFORWARD, {corner16(), corner16()});
                end
                3: begin
                    // no feedback: pure FIR with random taps
                    write_coef(CFG_FIRST_GAIN, $urandom);
                    write_coef(CFG_FIRST_FEEDBACK, '0);
                    write_coef(CFG_FIRST_FEEDFORWARD, $urandom);
                    write_coef(CFG_SECOND_GAIN, $urandom);
                    write_coef(CFG_SECOND_FEEDBACK, '0);
                    write_coef(CFG_SECOND_FEEDFORWARD, $urandom);
                end
                default: begin
                    // calm first section feeding a random second one
                    write_coef(CFG_FIRST_GAIN, {16'h0000, g1});
                    write_coef(CFG_FIRST_FEEDBACK, CALM_FEEDBACK);
                    write_coef(CFG_FIRST_FEEDFORWARD, CALM_FEEDFORWARD);
                    write_coef(CFG_SECOND_GAIN, $urandom);
                    write_coef(CFG_SECOND_FEEDBACK, $urandom);
                    write_coef(CFG_SECOND_FEEDFORWARD, $urandom);
                end
            endcase
            // last phase runs with no idling on either side
            if (ph == NUM_PHASES - 1)
                quiet_tail = 1'b1;
            repeat (PHASE_LEN) begin
                s = ($urandom_range(0, 7) == 0) ? corner16() : 16'($urandom);
                send_sample(s, 1'b0, '0);
            end
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (filtered_due.size() != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
